// ----- rtl/chr_pkg.sv -----
package chr_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 24;
  localparam int unsigned PHASE_FRAC_BITS_DEF = 24;
  localparam int unsigned TAPS                = 4;
  localparam int unsigned MAX_OUT             = 4;

  // Step ratio reset value, given in Q4.24 and rescaled to the phase format
  localparam longint unsigned STEP_RATIO_RESET_Q24 = 64'd18260915;
  localparam int unsigned     RESET_FRAC_BITS      = 24;

  // Register indexes
  localparam logic REG_STEP_RATIO   = 1'b0;
  localparam logic REG_RIGHT_ENABLE = 1'b1;

endpackage

// ----- rtl/chr_lane.sv -----
module chr_lane #(
  parameter int unsigned SAMPLE_BITS     = chr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_FRAC_BITS = chr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [chr_pkg::TAPS-1:0][SAMPLE_BITS-1:0]     taps_i,
  input  logic [PHASE_FRAC_BITS-1:0]                    t_i,
  output logic                                          done_o,
  output logic [SAMPLE_BITS-1:0]                        result_o
);
  import chr_pkg::*;

  localparam int unsigned AW   = SAMPLE_BITS + 5;
  localparam int unsigned LO   = PHASE_FRAC_BITS / 2;
  localparam int unsigned HI   = PHASE_FRAC_BITS - LO;
  localparam int unsigned PLW  = AW + LO + 1;
  localparam int unsigned PHW  = AW + HI + 1;
  localparam int unsigned SW   = AW + HI + 2;

  localparam logic signed [AW-1:0] ONE_S = AW'(64'sd1);
  localparam logic signed [AW-1:0] SMAX  = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SMIN  = -SMAX - ONE_S;

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_LO   = 2'd1;
  localparam logic [1:0] CS_HI   = 2'd2;
  localparam logic [1:0] CS_FIN  = 2'd3;

  logic [1:0]                 state_q;
  logic [1:0]                 step_q;
  logic signed [AW-1:0]       acc_q, b_q, c_q, d_q;
  logic [PHASE_FRAC_BITS-1:0] t_q;
  logic signed [PLW-1:0]      plo_q;
  logic [SAMPLE_BITS-1:0]     res_q;
  logic                       done_q;

  logic signed [AW-1:0]  x0, x1, x2, x3;
  logic signed [AW-1:0]  a_c, b_c, c_c, d_c;
  logic signed [PLW-1:0] plo;
  logic signed [PHW-1:0] phi;
  logic signed [SW-1:0]  psum, pshift;
  logic signed [AW-1:0]  addend, acc_d, rnd;
  logic [SAMPLE_BITS-1:0] sat;

  assign x0 = AW'($signed(taps_i[0]));
  assign x1 = AW'($signed(taps_i[1]));
  assign x2 = AW'($signed(taps_i[2]));
  assign x3 = AW'($signed(taps_i[3]));

  // Twice the Catmull-Rom coefficients
  assign a_c = (x3 - x0) + ((x1 - x2) <<< 1) + (x1 - x2);
  assign b_c = (x0 <<< 1) - ((x1 <<< 2) + x1) + (x2 <<< 2) - x3;
  assign c_c = x2 - x0;
  assign d_c = x1 <<< 1;

  // acc * t split into two half-width products, floor division by 2^F overall
  assign plo    = acc_q * $signed({1'b0, t_q[LO-1:0]});
  assign phi    = acc_q * $signed({1'b0, t_q[PHASE_FRAC_BITS-1:LO]});
  assign psum   = SW'(phi) + SW'(plo_q >>> LO);
  assign pshift = psum >>> HI;

  always_comb begin
    case (step_q)
      2'd0:    addend = b_q;
      2'd1:    addend = c_q;
      default: addend = d_q;
    endcase
  end

  assign acc_d = AW'(pshift) + addend;

  // Round half up, then clamp to the sample range
  assign rnd = (acc_q + ONE_S) >>> 1;

  always_comb begin
    if (rnd > SMAX) begin
      sat = SMAX[SAMPLE_BITS-1:0];
    end else if (rnd < SMIN) begin
      sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      step_q  <= 2'd0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      state_q <= CS_LO;
      step_q  <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        CS_LO:  state_q <= CS_HI;
        CS_HI: begin
          if (step_q == 2'd2) begin
            state_q <= CS_FIN;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= CS_LO;
          end
        end
        CS_FIN: begin
          done_q  <= 1'b1;
          state_q <= CS_IDLE;
        end
        default: state_q <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= a_c;
      b_q   <= b_c;
      c_q   <= c_c;
      d_q   <= d_c;
      t_q   <= t_i;
    end else if (state_q == CS_LO) begin
      plo_q <= plo;
    end else if (state_q == CS_HI) begin
      acc_q <= acc_d;
    end else if (state_q == CS_FIN) begin
      res_q <= sat;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- rtl/chr_merge.sv -----
module chr_merge #(
  parameter int unsigned SAMPLE_BITS = chr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [SAMPLE_BITS-1:0] left_i,
  input  logic [SAMPLE_BITS-1:0] right_i,
  input  logic                   right_en_i,
  input  logic                   last_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] left_o,
  output logic [SAMPLE_BITS-1:0] right_o,
  output logic                   last_o
);
  import chr_pkg::*;

  logic                   valid_q;
  logic [SAMPLE_BITS-1:0] left_q, right_q;
  logic                   last_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= left_i;
      right_q <= right_en_i ? right_i : '0;
      last_q  <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign left_o      = left_q;
  assign right_o     = right_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/cubic_hermite_resampler.sv -----
// Stereo Catmull-Rom resampler: one source pair in, zero to four output pairs out.
// Each result is computed by both lanes after the input transfer; the next result of
// the same input starts once the previous one is loaded for output. The rate is set
// by the three-step Horner loop in each lane, two half-width multiplies per step,
// unless the output stalls. Inputs are taken only when the previous one is finished.
// Reset (async, active low) clears history, phase and priming, restores registers.
module cubic_hermite_resampler #(
  parameter int unsigned SAMPLE_BITS     = chr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PHASE_FRAC_BITS = chr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       src_left_i,
  input  logic [SAMPLE_BITS-1:0]       src_right_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SAMPLE_BITS-1:0]       left_sample_o,
  output logic [SAMPLE_BITS-1:0]       right_sample_o,
  output logic                         last_in_run_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [PHASE_FRAC_BITS+3:0]   cfg_data_i
);
  import chr_pkg::*;

  localparam int unsigned PW = PHASE_FRAC_BITS + 4;
  localparam logic [PW-1:0] PHASE_ONE = PW'(64'd1 << PHASE_FRAC_BITS);
  localparam logic [PW-1:0] STEP_RST  =
      PW'((STEP_RATIO_RESET_Q24 << PHASE_FRAC_BITS) >> RESET_FRAC_BITS);
  localparam int unsigned TW = $clog2(TAPS);
  localparam int unsigned NW = $clog2(MAX_OUT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]                        state_q;
  logic [TAPS-1:0][SAMPLE_BITS-1:0]  hist_l_q, hist_r_q;
  logic [PW-1:0]                     phase_q;
  logic [TW:0]                       fill_q;
  logic [NW-1:0]                     n_q;
  logic                              last_q;
  logic [PW-1:0]                     step_q;
  logic                              ren_q;

  logic          in_xfer, start, load, free;
  logic          done_l, done_r;
  logic [SAMPLE_BITS-1:0] res_l, res_r;
  logic [PW:0]   phase_sum;
  logic [PW-1:0] phase_adv;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Phase advance saturates at the top of the range
  assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};
  assign phase_adv = phase_sum[PW] ? '1 : phase_sum[PW-1:0];

  assign start = (state_q == ST_CHECK) && (phase_q < PHASE_ONE);
  assign load  = (state_q == ST_EVAL) && done_l && done_r && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RST;
      ren_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STEP_RATIO:   step_q <= cfg_data_i;
        REG_RIGHT_ENABLE: ren_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hist_l_q <= '0;
      hist_r_q <= '0;
      phase_q  <= '0;
      fill_q   <= '0;
      n_q      <= '0;
      last_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            n_q <= '0;
            if (fill_q < (TW+1)'(TAPS)) begin
              hist_l_q[fill_q[TW-1:0]] <= src_left_i;
              hist_r_q[fill_q[TW-1:0]] <= src_right_i;
              fill_q <= fill_q + (TW+1)'(1);
              if (fill_q == (TW+1)'(TAPS - 1)) begin
                phase_q <= '0;
                state_q <= ST_CHECK;
              end
            end else begin
              hist_l_q <= {src_left_i, hist_l_q[TAPS-1:1]};
              hist_r_q <= {src_right_i, hist_r_q[TAPS-1:1]};
              phase_q  <= (phase_q >= PHASE_ONE) ? phase_q - PHASE_ONE : '0;
              state_q  <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (start) begin
            phase_q <= phase_adv;
            last_q  <= (phase_adv >= PHASE_ONE) || (n_q == NW'(MAX_OUT - 1));
            state_q <= ST_EVAL;
          end else begin
            // phase still at or past one after the shift: this input is skipped
            state_q <= ST_IDLE;
          end
        end
        ST_EVAL: begin
          if (load) begin
            n_q     <= n_q + NW'(1);
            state_q <= last_q ? ST_IDLE : ST_CHECK;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  chr_lane #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .taps_i   (hist_l_q),
    .t_i      (phase_q[PHASE_FRAC_BITS-1:0]),
    .done_o   (done_l),
    .result_o (res_l)
  );

  chr_lane #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .taps_i   (hist_r_q),
    .t_i      (phase_q[PHASE_FRAC_BITS-1:0]),
    .done_o   (done_r),
    .result_o (res_r)
  );

  chr_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .left_i      (res_l),
    .right_i     (res_r),
    .right_en_i  (ren_q),
    .last_i      (last_q),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_o      (left_sample_o),
    .right_o     (right_sample_o),
    .last_o      (last_in_run_o)
  );

endmodule
